[rtl/core/sst_pkg.sv]
// Shared types, token codes and character tables of the script source tokenizer.
// No dependencies; every other file of the block uses this package.
`default_nettype none
package sst_pkg;

  localparam int MAX_TOKEN_SLOTS_DEFAULT = 1024;
  localparam int TEXT_CAP_DEFAULT        = 63;
  localparam int PREFIX_DEPTH            = 9;
  localparam int MAX_RECORDS             = 4;
  localparam int QUEUE_DEPTH             = 2;
  localparam int KEYWORD_COUNT           = 13;

  // record kinds
  localparam logic RK_TEXT  = 1'b0;
  localparam logic RK_TOKEN = 1'b1;

  // token codes
  localparam logic [5:0] TK_NUMBER  = 6'd0;
  localparam logic [5:0] TK_STRING  = 6'd1;
  localparam logic [5:0] TK_IDENT   = 6'd2;
  localparam logic [5:0] TK_KW_BASE = 6'd3;
  localparam logic [5:0] TK_SEQ     = 6'd16;
  localparam logic [5:0] TK_SNE     = 6'd17;
  localparam logic [5:0] TK_EQ      = 6'd18;
  localparam logic [5:0] TK_NE      = 6'd19;
  localparam logic [5:0] TK_LE      = 6'd20;
  localparam logic [5:0] TK_GE      = 6'd21;
  localparam logic [5:0] TK_AND     = 6'd22;
  localparam logic [5:0] TK_OR      = 6'd23;
  localparam logic [5:0] TK_INC     = 6'd24;
  localparam logic [5:0] TK_DEC     = 6'd25;
  localparam logic [5:0] TK_ADDEQ   = 6'd26;
  localparam logic [5:0] TK_SUBEQ   = 6'd27;
  localparam logic [5:0] TK_LPAREN  = 6'd28;
  localparam logic [5:0] TK_RPAREN  = 6'd29;
  localparam logic [5:0] TK_LBRACE  = 6'd30;
  localparam logic [5:0] TK_RBRACE  = 6'd31;
  localparam logic [5:0] TK_LBRACK  = 6'd32;
  localparam logic [5:0] TK_RBRACK  = 6'd33;
  localparam logic [5:0] TK_SEMI    = 6'd34;
  localparam logic [5:0] TK_COMMA   = 6'd35;
  localparam logic [5:0] TK_DOT     = 6'd36;
  localparam logic [5:0] TK_ASSIGN  = 6'd37;
  localparam logic [5:0] TK_PLUS    = 6'd38;
  localparam logic [5:0] TK_MINUS   = 6'd39;
  localparam logic [5:0] TK_STAR    = 6'd40;
  localparam logic [5:0] TK_SLASH   = 6'd41;
  localparam logic [5:0] TK_PERCENT = 6'd42;
  localparam logic [5:0] TK_LT      = 6'd43;
  localparam logic [5:0] TK_GT      = 6'd44;
  localparam logic [5:0] TK_BANG    = 6'd45;
  localparam logic [5:0] TK_UNKNOWN = 6'd46;
  localparam logic [5:0] TK_END     = 6'd47;

  // keywords, right aligned, first character in the highest used byte
  localparam logic [71:0] KW_TEXT [KEYWORD_COUNT] = '{
    72'("var"), 72'("let"), 72'("const"), 72'("function"), 72'("return"),
    72'("if"), 72'("else"), 72'("for"), 72'("while"), 72'("true"),
    72'("false"), 72'("null"), 72'("undefined")
  };
  localparam int KW_LEN [KEYWORD_COUNT] = '{3, 3, 5, 8, 6, 2, 4, 3, 5, 4, 5, 4, 9};

  typedef struct packed {
    logic       kind;
    logic [5:0] tok;
    logic [7:0] ch;
    logic [63:0] mant;
    logic [7:0] frac;
    logic [9:0] pos;
  } record_t;

  typedef struct packed {
    logic [2:0]                     cnt;
    record_t [MAX_RECORDS-1:0]      recs;
  } bundle_t;

  function automatic logic is_alpha_ish(input logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_" || b == "$";
  endfunction

  function automatic logic is_dig(input logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic logic is_ws(input logic [7:0] b);
    return b == " " || (b >= 8'd9 && b <= 8'd13);
  endfunction

  function automatic logic [5:0] single_code(input logic [7:0] b);
    logic [5:0] k;
    case (b)
      "(":     k = TK_LPAREN;
      ")":     k = TK_RPAREN;
      "{":     k = TK_LBRACE;
      "}":     k = TK_RBRACE;
      "[":     k = TK_LBRACK;
      "]":     k = TK_RBRACK;
      ";":     k = TK_SEMI;
      ",":     k = TK_COMMA;
      ".":     k = TK_DOT;
      "=":     k = TK_ASSIGN;
      "+":     k = TK_PLUS;
      "-":     k = TK_MINUS;
      "*":     k = TK_STAR;
      "/":     k = TK_SLASH;
      "%":     k = TK_PERCENT;
      "<":     k = TK_LT;
      ">":     k = TK_GT;
      "!":     k = TK_BANG;
      default: k = TK_UNKNOWN;
    endcase
    return k;
  endfunction

endpackage
`default_nettype wire

[rtl/core/script_source_tokenizer.sv]
// Script source tokenizer: top level joining front end, bundle queue and back end.
// Depends on sst_pkg, sst_front, sst_queue and sst_back.
//
// Input channel (in_valid / in_stall): one source byte per request, with
// final_byte marking the last byte; a zero byte also ends the source.
// Output channel (out_valid / out_stall): one record per request, text
// characters of strings and identifiers first, then the completed token;
// run_end marks the last record a byte caused.
// A taken byte's bundle is written into the queue, then its records are
// loaded one by one into the output register. Throughput: one byte per
// cycle while no byte gives over one record and the receiver does not
// stall; the back end drains one record per cycle unless stalled, so a byte
// with several records holds the queue head longer, which the two-entry
// queue absorbs before in_stall rises; bytes giving no record never reach it.
// Reset: synchronous; lexer idle, counters cleared, queue and output empty.
// When the receiver stalls, hold the output record; the queue fills and then
// the input stalls. After the end token every later byte is taken and dropped.
`default_nettype none
module script_source_tokenizer #(
  parameter int MAX_TOKEN_SLOTS = sst_pkg::MAX_TOKEN_SLOTS_DEFAULT,
  parameter int TEXT_CAP        = sst_pkg::TEXT_CAP_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output      logic        in_stall,
  input  wire logic [7:0]  source_byte,
  input  wire logic        final_byte,
  output      logic        out_valid,
  input  wire logic        out_stall,
  output      logic        record_kind,
  output      logic [5:0]  token_kind,
  output      logic [7:0]  text_char,
  output      logic [63:0] number_mantissa,
  output      logic [7:0]  fraction_digits,
  output      logic [9:0]  token_position,
  output      logic        run_end
);

  logic             push;
  logic             pop;
  logic             full;
  logic             head_valid;
  sst_pkg::bundle_t push_bundle;
  sst_pkg::bundle_t head;

  // classify each byte and build its record bundle
  sst_front #(
    .MAX_TOKEN_SLOTS (MAX_TOKEN_SLOTS),
    .TEXT_CAP        (TEXT_CAP)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .source_byte (source_byte),
    .final_byte  (final_byte),
    .queue_full  (full),
    .push        (push),
    .push_bundle (push_bundle)
  );

  // decouple the two sides
  sst_queue u_queue (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .push_bundle (push_bundle),
    .pop         (pop),
    .full        (full),
    .head_valid  (head_valid),
    .head        (head)
  );

  // serialise bundles into output records
  sst_back u_back (
    .clk             (clk),
    .rst             (rst),
    .head_valid      (head_valid),
    .head            (head),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .record_kind     (record_kind),
    .token_kind      (token_kind),
    .text_char       (text_char),
    .number_mantissa (number_mantissa),
    .fraction_digits (fraction_digits),
    .token_position  (token_position),
    .run_end         (run_end)
  );

endmodule
`default_nettype wire

[rtl/core/sst_front.sv]
// Front end of the tokenizer: accepts source bytes, runs the lexer state and
// builds the bundle of records each byte causes. Depends on sst_pkg.
`default_nettype none
module sst_front #(
  parameter int MAX_TOKEN_SLOTS = sst_pkg::MAX_TOKEN_SLOTS_DEFAULT,
  parameter int TEXT_CAP        = sst_pkg::TEXT_CAP_DEFAULT
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output      logic              in_stall,
  input  wire logic [7:0]        source_byte,
  input  wire logic              final_byte,
  input  wire logic              queue_full,
  output      logic              push,
  output      sst_pkg::bundle_t  push_bundle
);

  localparam int CW = (MAX_TOKEN_SLOTS > 2) ? $clog2(MAX_TOKEN_SLOTS) : 1;
  localparam int LW = $clog2(TEXT_CAP + 1);
  localparam logic [CW-1:0] TOKEN_LIMIT = CW'(MAX_TOKEN_SLOTS - 1);
  localparam logic [LW-1:0] TEXT_LIMIT  = LW'(TEXT_CAP);

  typedef enum logic [11:0] {
    M_IDLE       = 12'b0000_0000_0001,
    M_LINE       = 12'b0000_0000_0010,
    M_BLOCK      = 12'b0000_0000_0100,
    M_BLOCK_STAR = 12'b0000_0000_1000,
    M_INT        = 12'b0000_0001_0000,
    M_FRAC       = 12'b0000_0010_0000,
    M_STR        = 12'b0000_0100_0000,
    M_STR_ESC    = 12'b0000_1000_0000,
    M_STR_FULL   = 12'b0001_0000_0000,
    M_IDENT      = 12'b0010_0000_0000,
    M_OP1        = 12'b0100_0000_0000,
    M_OP2        = 12'b1000_0000_0000
  } mode_t;

  typedef struct packed {
    mode_t                                   mode;
    logic [7:0]                              held;
    logic [LW-1:0]                           tlen;
    logic [63:0]                             mant;
    logic [7:0]                              frac;
    logic [sst_pkg::PREFIX_DEPTH-1:0][7:0]   pre;
    logic                                    qs;
    logic [CW-1:0]                           toks;
    logic                                    ended;
  } st_t;

  typedef struct packed {
    st_t              s;
    sst_pkg::bundle_t b;
  } ctx_t;

  st_t  st;
  ctx_t nx;
  logic accept;

  function automatic ctx_t put(input ctx_t x, input logic kind, input logic [5:0] tok,
                               input logic [7:0] ch, input logic [63:0] m,
                               input logic [7:0] f);
    if (x.b.cnt < 3'(sst_pkg::MAX_RECORDS)) begin
      x.b.recs[x.b.cnt[1:0]] = '{kind: kind, tok: tok, ch: ch, mant: m, frac: f,
                                 pos: 10'(x.s.toks)};
      x.b.cnt = x.b.cnt + 3'd1;
    end
    return x;
  endfunction

  function automatic ctx_t close_source(input ctx_t x);
    if (!x.s.ended) begin
      x = put(x, sst_pkg::RK_TOKEN, sst_pkg::TK_END, 8'd0, 64'd0, 8'd0);
      x.s.toks  = x.s.toks + CW'(1);
      x.s.ended = 1'b1;
    end
    x.s.mode = M_IDLE;
    return x;
  endfunction

  function automatic ctx_t emit_token(input ctx_t x, input logic [5:0] tok,
                                      input logic [63:0] m, input logic [7:0] f);
    if (x.s.ended) return x;
    x = put(x, sst_pkg::RK_TOKEN, tok, 8'd0, m, f);
    x.s.toks = x.s.toks + CW'(1);
    if (x.s.toks >= TOKEN_LIMIT) x = close_source(x);
    return x;
  endfunction

  function automatic ctx_t add_text(input ctx_t x, input logic [7:0] b,
                                    input logic [5:0] kind);
    if (x.s.tlen < LW'(sst_pkg::PREFIX_DEPTH)) x.s.pre[x.s.tlen[3:0]] = b;
    x.s.tlen = x.s.tlen + LW'(1);
    return put(x, sst_pkg::RK_TEXT, kind, b, 64'd0, 8'd0);
  endfunction

  function automatic ctx_t add_digit(input ctx_t x, input logic [7:0] b);
    logic [67:0] v;
    v = {1'b0, x.s.mant, 3'd0} + {3'd0, x.s.mant, 1'b0} + {64'd0, b[3:0]};
    x.s.mant = (v[67:64] != 4'd0) ? '1 : v[63:0];
    return x;
  endfunction

  function automatic ctx_t emit_ident(input ctx_t x);
    logic [5:0] code;
    logic       hit;
    code = sst_pkg::TK_IDENT;
    for (int i = 0; i < sst_pkg::KEYWORD_COUNT; i++) begin
      if (code == sst_pkg::TK_IDENT && x.s.tlen == LW'(sst_pkg::KW_LEN[i])) begin
        hit = 1'b1;
        for (int j = 0; j < sst_pkg::PREFIX_DEPTH; j++) begin
          if (j < sst_pkg::KW_LEN[i]) begin
            if (x.s.pre[j] != sst_pkg::KW_TEXT[i][8*(sst_pkg::KW_LEN[i]-1-j) +: 8]) hit = 1'b0;
          end
        end
        if (hit) code = sst_pkg::TK_KW_BASE + 6'(i);
      end
    end
    return emit_token(x, code, 64'd0, 8'd0);
  endfunction

  function automatic ctx_t start_byte(input ctx_t x, input logic [7:0] b);
    if (x.s.ended) return x;
    x.s.mode = M_IDLE;
    if (sst_pkg::is_ws(b)) return x;
    if (sst_pkg::is_dig(b)) begin
      x.s.mode = M_INT;
      x.s.mant = 64'd0;
      x.s.frac = 8'd0;
      return add_digit(x, b);
    end
    if (b == "\"" || b == "'") begin
      x.s.mode = M_STR;
      x.s.qs   = (b == "'");
      x.s.tlen = '0;
      return x;
    end
    if (sst_pkg::is_alpha_ish(b)) begin
      x.s.mode = M_IDENT;
      x.s.tlen = '0;
      return add_text(x, b, sst_pkg::TK_IDENT);
    end
    if (b == "=" || b == "!" || b == "<" || b == ">" || b == "&" || b == "|" ||
        b == "+" || b == "-" || b == "/") begin
      x.s.mode = M_OP1;
      x.s.held = b;
      return x;
    end
    return emit_token(x, sst_pkg::single_code(b), 64'd0, 8'd0);
  endfunction

  function automatic ctx_t str_char(input ctx_t x, input logic [7:0] b);
    x = add_text(x, b, sst_pkg::TK_STRING);
    x.s.mode = (x.s.tlen >= TEXT_LIMIT) ? M_STR_FULL : M_STR;
    return x;
  endfunction

  function automatic ctx_t step_op1(input ctx_t x, input logic [7:0] b);
    logic [7:0] h;
    h = x.s.held;
    x.s.mode = M_IDLE;
    if (h == "/") begin
      if (b == "/") begin x.s.mode = M_LINE;  return x; end
      if (b == "*") begin x.s.mode = M_BLOCK; return x; end
    end else if ((h == "=" || h == "!") && b == "=") begin
      x.s.mode = M_OP2;
      return x;
    end
    else if (h == "<" && b == "=") return emit_token(x, sst_pkg::TK_LE, 64'd0, 8'd0);
    else if (h == ">" && b == "=") return emit_token(x, sst_pkg::TK_GE, 64'd0, 8'd0);
    else if (h == "&" && b == "&") return emit_token(x, sst_pkg::TK_AND, 64'd0, 8'd0);
    else if (h == "|" && b == "|") return emit_token(x, sst_pkg::TK_OR, 64'd0, 8'd0);
    else if (h == "+" && b == "+") return emit_token(x, sst_pkg::TK_INC, 64'd0, 8'd0);
    else if (h == "-" && b == "-") return emit_token(x, sst_pkg::TK_DEC, 64'd0, 8'd0);
    else if (h == "+" && b == "=") return emit_token(x, sst_pkg::TK_ADDEQ, 64'd0, 8'd0);
    else if (h == "-" && b == "=") return emit_token(x, sst_pkg::TK_SUBEQ, 64'd0, 8'd0);
    x = emit_token(x, sst_pkg::single_code(h), 64'd0, 8'd0);
    return start_byte(x, b);
  endfunction

  function automatic ctx_t step_byte(input ctx_t x, input logic [7:0] b);
    logic [7:0] q;
    q = x.s.qs ? 8'("'") : 8'("\"");
    case (x.s.mode)
      M_LINE:  if (b == "\n") x.s.mode = M_IDLE;
      M_BLOCK: if (b == "*") x.s.mode = M_BLOCK_STAR;
      M_BLOCK_STAR: begin
        if (b == "/") x.s.mode = M_IDLE;
        else if (b != "*") x.s.mode = M_BLOCK;
      end
      M_INT: begin
        if (sst_pkg::is_dig(b)) x = add_digit(x, b);
        else if (b == ".") x.s.mode = M_FRAC;
        else begin
          x.s.mode = M_IDLE;
          x = emit_token(x, sst_pkg::TK_NUMBER, x.s.mant, x.s.frac);
          x = start_byte(x, b);
        end
      end
      M_FRAC: begin
        if (sst_pkg::is_dig(b)) begin
          x = add_digit(x, b);
          if (x.s.frac != 8'hFF) x.s.frac = x.s.frac + 8'd1;
        end else begin
          x.s.mode = M_IDLE;
          x = emit_token(x, sst_pkg::TK_NUMBER, x.s.mant, x.s.frac);
          x = start_byte(x, b);
        end
      end
      M_STR: begin
        if (b == q) begin
          x.s.mode = M_IDLE;
          x = emit_token(x, sst_pkg::TK_STRING, 64'd0, 8'd0);
        end else if (b == "\\") x.s.mode = M_STR_ESC;
        else x = str_char(x, b);
      end
      M_STR_ESC: x = str_char(x, (b == "n") ? 8'd10 : ((b == "t") ? 8'd9 : b));
      M_STR_FULL: begin
        x.s.mode = M_IDLE;
        x = emit_token(x, sst_pkg::TK_STRING, 64'd0, 8'd0);
        if (b != q) x = start_byte(x, b);
      end
      M_IDENT: begin
        if (x.s.tlen < TEXT_LIMIT && (sst_pkg::is_alpha_ish(b) || sst_pkg::is_dig(b)))
          x = add_text(x, b, sst_pkg::TK_IDENT);
        else begin
          x.s.mode = M_IDLE;
          x = emit_ident(x);
          x = start_byte(x, b);
        end
      end
      M_OP1: x = step_op1(x, b);
      M_OP2: begin
        x.s.mode = M_IDLE;
        if (b == "=")
          x = emit_token(x, (x.s.held == "=") ? sst_pkg::TK_SEQ : sst_pkg::TK_SNE,
                         64'd0, 8'd0);
        else begin
          x = emit_token(x, (x.s.held == "=") ? sst_pkg::TK_EQ : sst_pkg::TK_NE,
                         64'd0, 8'd0);
          x = start_byte(x, b);
        end
      end
      default: x = start_byte(x, b);
    endcase
    return x;
  endfunction

  function automatic ctx_t flush_source(input ctx_t x);
    mode_t m;
    m = x.s.mode;
    x.s.mode = M_IDLE;
    case (m)
      M_INT, M_FRAC: x = emit_token(x, sst_pkg::TK_NUMBER, x.s.mant, x.s.frac);
      M_STR_ESC: begin
        x = add_text(x, "\\", sst_pkg::TK_STRING);
        x = emit_token(x, sst_pkg::TK_STRING, 64'd0, 8'd0);
      end
      M_STR, M_STR_FULL: x = emit_token(x, sst_pkg::TK_STRING, 64'd0, 8'd0);
      M_IDENT: x = emit_ident(x);
      M_OP1: x = emit_token(x, sst_pkg::single_code(x.s.held), 64'd0, 8'd0);
      M_OP2: x = emit_token(x, (x.s.held == "=") ? sst_pkg::TK_EQ : sst_pkg::TK_NE,
                            64'd0, 8'd0);
      default: ;
    endcase
    return close_source(x);
  endfunction

  always_comb begin
    nx.s     = st;
    nx.b     = '0;
    if (!st.ended) begin
      if (source_byte == 8'd0) nx = flush_source(nx);
      else begin
        nx = step_byte(nx, source_byte);
        if (final_byte && !nx.s.ended) nx = flush_source(nx);
      end
    end
  end

  assign in_stall    = queue_full;
  assign accept      = in_valid && !queue_full;
  assign push        = accept && (nx.b.cnt != 3'd0);
  assign push_bundle = nx.b;

  // keyword prefix is written only when used and has no reset
  always_ff @(posedge clk) begin
    if (rst) begin
      st.mode  <= M_IDLE;
      st.held  <= 8'd0;
      st.tlen  <= '0;
      st.mant  <= 64'd0;
      st.frac  <= 8'd0;
      st.qs    <= 1'b0;
      st.toks  <= '0;
      st.ended <= 1'b0;
    end else if (accept) begin
      st.mode  <= nx.s.mode;
      st.held  <= nx.s.held;
      st.tlen  <= nx.s.tlen;
      st.mant  <= nx.s.mant;
      st.frac  <= nx.s.frac;
      st.pre   <= nx.s.pre;
      st.qs    <= nx.s.qs;
      st.toks  <= nx.s.toks;
      st.ended <= nx.s.ended;
    end
  end

endmodule
`default_nettype wire

[rtl/core/sst_queue.sv]
// Short queue of record bundles between the front and back ends.
// Depends on sst_pkg.
`default_nettype none
module sst_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire sst_pkg::bundle_t  push_bundle,
  input  wire logic              pop,
  output      logic              full,
  output      logic              head_valid,
  output      sst_pkg::bundle_t  head
);

  localparam int PW = (sst_pkg::QUEUE_DEPTH > 1) ? $clog2(sst_pkg::QUEUE_DEPTH) : 1;
  localparam int NW = $clog2(sst_pkg::QUEUE_DEPTH + 1);

  sst_pkg::bundle_t mem [sst_pkg::QUEUE_DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [NW-1:0]    count;

  assign full       = (count == NW'(sst_pkg::QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_bundle;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + PW'(1);
      if (pop)  rd_ptr <= rd_ptr + PW'(1);
      if (push && !pop) count <= count + NW'(1);
      else if (pop && !push) count <= count - NW'(1);
    end
  end

endmodule
`default_nettype wire

[rtl/core/sst_back.sv]
// Back end of the tokenizer: walks the head bundle one record a cycle, while
// the output is not stalled, into the output register. Depends on sst_pkg.
`default_nettype none
module sst_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              head_valid,
  input  wire sst_pkg::bundle_t  head,
  output      logic              pop,
  output      logic              out_valid,
  input  wire logic              out_stall,
  output      logic              record_kind,
  output      logic [5:0]        token_kind,
  output      logic [7:0]        text_char,
  output      logic [63:0]       number_mantissa,
  output      logic [7:0]        fraction_digits,
  output      logic [9:0]        token_position,
  output      logic              run_end
);

  logic [1:0]       idx;
  logic             load;
  logic             last;
  sst_pkg::record_t rec;

  assign load = head_valid && (!out_valid || !out_stall);
  assign last = ({1'b0, idx} + 3'd1) == head.cnt;
  assign pop  = load && last;
  assign rec  = head.recs[idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= 2'd0;
    end else if (load) begin
      out_valid <= 1'b1;
      idx       <= last ? 2'd0 : idx + 2'd1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      record_kind     <= rec.kind;
      token_kind      <= rec.tok;
      text_char       <= rec.ch;
      number_mantissa <= rec.mant;
      fraction_digits <= rec.frac;
      token_position  <= rec.pos;
      run_end         <= last;
    end
  end

endmodule
`default_nettype wire

[test/script_source_tokenizer_tb.sv]
// Self-checking testbench for script_source_tokenizer: drives one source text byte by byte
// and checks every record against an in-bench tokenizer model. Depends on sst_pkg and the RTL.
module script_source_tokenizer_tb;

  localparam int SLOT_COUNT  = 128;
  localparam int CAP         = 63;
  localparam int PREFIX_LEN  = 9;
  localparam int RECS_PER_B  = 4;
  localparam int IDLE_LIMIT  = 5000;
  localparam int RANDOM_BYTES = 230;

  typedef enum {L_IDLE, L_LINE, L_BLOCK, L_BLOCK_STAR, L_INT, L_FRAC, L_STR, L_STR_ESC,
                L_STR_FULL, L_IDENT, L_OP1, L_OP2} lex_mode_e;

  typedef struct packed {
    bit        kind;
    bit [5:0]  tok;
    bit [7:0]  ch;
    bit [63:0] mant;
    bit [7:0]  frac;
    bit [9:0]  pos;
    bit        last;
  } lex_record_t;

  // Token tracker: mirrors the lexer state, predicts the records of each accepted
  // request and compares the block's records against them in order.
  class token_tracker;
    lex_mode_e   mode;
    bit [7:0]    held;
    int          tlen;
    bit [63:0]   mant;
    int          fcnt;
    bit [7:0]    prefix [PREFIX_LEN];
    bit          single_q;
    int          emitted;
    bit          closed;
    string       kw_words [13];
    lex_record_t step_recs [$];
    lex_record_t expected_records [$];
    int          errors;
    int          reported;

    function new();
      kw_words = '{"var", "let", "const", "function", "return", "if", "else", "for",
                   "while", "true", "false", "null", "undefined"};
      mode = L_IDLE;
    endfunction

    function bit alpha_ish(bit [7:0] b);
      return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_" || b == "$";
    endfunction
    function bit digit(bit [7:0] b);
      return b >= "0" && b <= "9";
    endfunction
    function bit blank(bit [7:0] b);
      return b == " " || (b >= 8'd9 && b <= 8'd13);
    endfunction

    function bit [5:0] punct_kind(bit [7:0] b);
      case (b)
        "(": return sst_pkg::TK_LPAREN;   ")": return sst_pkg::TK_RPAREN;
        "{": return sst_pkg::TK_LBRACE;   "}": return sst_pkg::TK_RBRACE;
        "[": return sst_pkg::TK_LBRACK;   "]": return sst_pkg::TK_RBRACK;
        ";": return sst_pkg::TK_SEMI;     ",": return sst_pkg::TK_COMMA;
        ".": return sst_pkg::TK_DOT;      "=": return sst_pkg::TK_ASSIGN;
        "+": return sst_pkg::TK_PLUS;     "-": return sst_pkg::TK_MINUS;
        "*": return sst_pkg::TK_STAR;     "/": return sst_pkg::TK_SLASH;
        "%": return sst_pkg::TK_PERCENT;  "<": return sst_pkg::TK_LT;
        ">": return sst_pkg::TK_GT;       "!": return sst_pkg::TK_BANG;
        default: return sst_pkg::TK_UNKNOWN;
      endcase
    endfunction

    function void push(bit kind, bit [5:0] tok, bit [7:0] ch, bit [63:0] m, bit [7:0] f);
      lex_record_t r;
      if (step_recs.size() >= RECS_PER_B) return;
      r.kind = kind; r.tok = tok; r.ch = ch; r.mant = m; r.frac = f;
      r.pos = emitted[9:0]; r.last = 0;
      step_recs.push_back(r);
    endfunction

    function void close_src();
      if (!closed) begin
        push(sst_pkg::RK_TOKEN, sst_pkg::TK_END, 0, 0, 0);
        emitted++;
        closed = 1;
      end
      mode = L_IDLE;
    endfunction

    function void emit(bit [5:0] tok, bit [63:0] m, bit [7:0] f);
      if (closed) return;
      push(sst_pkg::RK_TOKEN, tok, 0, m, f);
      emitted++;
      if (emitted >= SLOT_COUNT - 1) close_src();
    endfunction

    function void add_text(bit [7:0] b, bit [5:0] kind);
      if (tlen < PREFIX_LEN) prefix[tlen] = b;
      tlen++;
      push(sst_pkg::RK_TEXT, kind, b, 0, 0);
    endfunction

    function void add_digit(bit [7:0] b);
      bit [63:0] d;
      d = 64'(b - "0");
      if (mant > ({64{1'b1}} - d) / 10) mant = {64{1'b1}};
      else mant = mant * 10 + d;
    endfunction

    function void emit_ident();
      bit [5:0] code;
      bit       same;
      code = sst_pkg::TK_IDENT;
      for (int i = 0; i < 13 && code == sst_pkg::TK_IDENT; i++) begin
        if (kw_words[i].len() != tlen) continue;
        same = 1;
        for (int j = 0; j < tlen; j++)
          if (kw_words[i][j] != prefix[j]) same = 0;
        if (same) code = sst_pkg::TK_KW_BASE + 6'(i);
      end
      emit(code, 0, 0);
    endfunction

    function void start(bit [7:0] b);
      if (closed) return;
      mode = L_IDLE;
      if (blank(b)) return;
      if (digit(b)) begin
        mode = L_INT; mant = 0; fcnt = 0; add_digit(b);
      end else if (b == "\"" || b == "'") begin
        mode = L_STR; single_q = (b == "'"); tlen = 0;
      end else if (alpha_ish(b)) begin
        mode = L_IDENT; tlen = 0; add_text(b, sst_pkg::TK_IDENT);
      end else if (b inside {"=", "!", "<", ">", "&", "|", "+", "-", "/"}) begin
        mode = L_OP1; held = b;
      end else begin
        emit(punct_kind(b), 0, 0);
      end
    endfunction

    function void str_char(bit [7:0] b);
      add_text(b, sst_pkg::TK_STRING);
      mode = (tlen >= CAP) ? L_STR_FULL : L_STR;
    endfunction

    function void op_second(bit [7:0] b);
      mode = L_IDLE;
      if (held == "/" && b == "/") begin mode = L_LINE; return; end
      if (held == "/" && b == "*") begin mode = L_BLOCK; return; end
      if ((held == "=" || held == "!") && b == "=") begin mode = L_OP2; return; end
      if (held == "<" && b == "=") begin emit(sst_pkg::TK_LE, 0, 0); return; end
      if (held == ">" && b == "=") begin emit(sst_pkg::TK_GE, 0, 0); return; end
      if (held == "&" && b == "&") begin emit(sst_pkg::TK_AND, 0, 0); return; end
      if (held == "|" && b == "|") begin emit(sst_pkg::TK_OR, 0, 0); return; end
      if (held == "+" && b == "+") begin emit(sst_pkg::TK_INC, 0, 0); return; end
      if (held == "-" && b == "-") begin emit(sst_pkg::TK_DEC, 0, 0); return; end
      if (held == "+" && b == "=") begin emit(sst_pkg::TK_ADDEQ, 0, 0); return; end
      if (held == "-" && b == "=") begin emit(sst_pkg::TK_SUBEQ, 0, 0); return; end
      emit(punct_kind(held), 0, 0);
      start(b);
    endfunction

    function void step(bit [7:0] b);
      bit [7:0] q;
      q = single_q ? "'" : "\"";
      case (mode)
        L_LINE: if (b == 8'd10) mode = L_IDLE;
        L_BLOCK: if (b == "*") mode = L_BLOCK_STAR;
        L_BLOCK_STAR: begin
          if (b == "/") mode = L_IDLE;
          else if (b != "*") mode = L_BLOCK;
        end
        L_INT: begin
          if (digit(b)) add_digit(b);
          else if (b == ".") mode = L_FRAC;
          else begin
            mode = L_IDLE; emit(sst_pkg::TK_NUMBER, mant, 8'(fcnt)); start(b);
          end
        end
        L_FRAC: begin
          if (digit(b)) begin add_digit(b); if (fcnt < 255) fcnt++; end
          else begin
            mode = L_IDLE; emit(sst_pkg::TK_NUMBER, mant, 8'(fcnt)); start(b);
          end
        end
        L_STR: begin
          if (b == q) begin mode = L_IDLE; emit(sst_pkg::TK_STRING, 0, 0); end
          else if (b == "\\") mode = L_STR_ESC;
          else str_char(b);
        end
        L_STR_ESC: str_char(b == "n" ? 8'd10 : (b == "t" ? 8'd9 : b));
        L_STR_FULL: begin
          mode = L_IDLE;
          emit(sst_pkg::TK_STRING, 0, 0);
          if (b != q) start(b);
        end
        L_IDENT: begin
          if (tlen < CAP && (alpha_ish(b) || digit(b))) add_text(b, sst_pkg::TK_IDENT);
          else begin mode = L_IDLE; emit_ident(); start(b); end
        end
        L_OP1: op_second(b);
        L_OP2: begin
          mode = L_IDLE;
          if (b == "=") emit(held == "=" ? sst_pkg::TK_SEQ : sst_pkg::TK_SNE, 0, 0);
          else begin
            emit(held == "=" ? sst_pkg::TK_EQ : sst_pkg::TK_NE, 0, 0); start(b);
          end
        end
        default: start(b);
      endcase
    endfunction

    function void flush();
      lex_mode_e m;
      m = mode;
      mode = L_IDLE;
      case (m)
        L_INT, L_FRAC: emit(sst_pkg::TK_NUMBER, mant, 8'(fcnt));
        L_STR_ESC: begin
          add_text("\\", sst_pkg::TK_STRING); emit(sst_pkg::TK_STRING, 0, 0);
        end
        L_STR, L_STR_FULL: emit(sst_pkg::TK_STRING, 0, 0);
        L_IDENT: emit_ident();
        L_OP1: emit(punct_kind(held), 0, 0);
        L_OP2: emit(held == "=" ? sst_pkg::TK_EQ : sst_pkg::TK_NE, 0, 0);
        default: ;
      endcase
      close_src();
    endfunction

    function void note_request(bit [7:0] b, bit fin);
      step_recs.delete();
      if (!closed) begin
        if (b == 0) flush();
        else begin
          step(b);
          if (fin && !closed) flush();
        end
      end
      if (step_recs.size() > 0) step_recs[$].last = 1;
      foreach (step_recs[i]) expected_records.push_back(step_recs[i]);
    endfunction

    function void check_record(lex_record_t got);
      lex_record_t want;
      if (expected_records.size() == 0) begin
        errors++;
        if (reported < 10) begin
          reported++;
          $display("unexpected record: kind %0d tok %0d ch %0d pos %0d",
                   got.kind, got.tok, got.ch, got.pos);
        end
        return;
      end
      want = expected_records.pop_front();
      if (got != want) begin
        errors++;
        if (reported < 10) begin
          reported++;
          $display({"record mismatch: expected kind %0d tok %0d ch %0d mant %0d",
                    " frac %0d pos %0d end %0d"},
                   want.kind, want.tok, want.ch, want.mant, want.frac, want.pos, want.last);
          $display({"                 actual   kind %0d tok %0d ch %0d mant %0d",
                    " frac %0d pos %0d end %0d"},
                   got.kind, got.tok, got.ch, got.mant, got.frac, got.pos, got.last);
        end
      end
    endfunction

    function int pending();
      return expected_records.size();
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        in_valid = 0;
  logic        in_stall;
  logic [7:0]  source_byte = 0;
  logic        final_byte = 0;
  logic        out_valid;
  logic        out_stall = 0;
  logic        record_kind;
  logic [5:0]  token_kind;
  logic [7:0]  text_char;
  logic [63:0] number_mantissa;
  logic [7:0]  fraction_digits;
  logic [9:0]  token_position;
  logic        run_end;

  token_tracker tracker = new();
  bit           quiet = 0;     // no idling on either side in the closing phase
  int           stall_left = 0;
  int           idle_cycles = 0;

  script_source_tokenizer #(
    .MAX_TOKEN_SLOTS(SLOT_COUNT), .TEXT_CAP(CAP)
  ) uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .source_byte(source_byte), .final_byte(final_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .record_kind(record_kind), .token_kind(token_kind), .text_char(text_char),
    .number_mantissa(number_mantissa), .fraction_digits(fraction_digits),
    .token_position(token_position), .run_end(run_end)
  );

  always #5 clk = ~clk;

  // Sample both handshakes at the rising edge; predict on requests, check on records.
  always @(posedge clk) begin
    lex_record_t got;
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (in_valid && !in_stall) tracker.note_request(source_byte, final_byte);
      if (out_valid && !out_stall) begin
        got.kind = record_kind; got.tok = token_kind; got.ch = text_char;
        got.mant = number_mantissa; got.frac = fraction_digits;
        got.pos = token_position; got.last = run_end;
        tracker.check_record(got);
      end
    end
  end

  // Watchdog: a stuck handshake ends the run.
  always @(posedge clk) begin
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Receiver stalls in random bursts; hold it low once the closing phase begins.
  always @(negedge clk) begin
    if (rst || quiet) begin
      out_stall <= 0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_stall <= 1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 9) == 0) begin
      out_stall <= 1;
      stall_left <= $urandom_range(0, 15);
    end else begin
      out_stall <= 0;
    end
  end

  // Send one request: entered and left at a falling edge.
  task automatic send_byte(input bit [7:0] b, input bit fin);
    if (!quiet && $urandom_range(0, 11) == 0) begin
      in_valid = 0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    in_valid = 1;
    source_byte = b;
    final_byte = fin;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    in_valid = 0;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], 0);
  endtask

  function automatic bit [7:0] word_char(bit first);
    int r;
    r = $urandom_range(0, first ? 53 : 63);
    if (r < 26) return 8'("a" + r);
    if (r < 52) return 8'("A" + r - 26);
    if (r == 52) return "_";
    if (r == 53) return "$";
    return 8'("0" + (r - 54));
  endfunction

  // Build one well-formed fragment with random content, or a burst of noise.
  function automatic string fragment();
    string ops [20] = '{"===", "!==", "==", "!=", "<=", ">=", "&&", "||", "++", "--",
                        "+=", "-=", "=", "+", "-", "<", ">", "!", "&", "|"};
    string s;
    int    n;
    bit [7:0] c, q;
    s = "";
    case ($urandom_range(0, 9))
      0, 1: begin
        // long runs of digits saturate the mantissa, rare long tails the point count
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(19, 26) : $urandom_range(1, 6);
        repeat (n) s = {s, string'(8'("0" + $urandom_range(0, 9)))};
        if ($urandom_range(0, 1)) begin
          s = {s, "."};
          n = ($urandom_range(0, 60) == 0) ? 258 : $urandom_range(0, 4);
          repeat (n) s = {s, string'(8'("0" + $urandom_range(0, 9)))};
        end
      end
      2, 3: begin
        q = $urandom_range(0, 1) ? "'" : "\"";
        s = string'(q);
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 66) : $urandom_range(0, 8);
        repeat (n) begin
          if ($urandom_range(0, 5) == 0) begin
            s = {s, "\\"};
            case ($urandom_range(0, 3))
              0: c = "n";
              1: c = "t";
              2: c = q;
              default: c = 8'($urandom_range(1, 255));
            endcase
          end else begin
            c = 8'($urandom_range(32, 126));
          end
          s = {s, string'(c)};
        end
        s = {s, string'(q)};
      end
      4, 5: begin
        if ($urandom_range(0, 1)) begin
          case ($urandom_range(0, 12))
            0: s = "var";   1: s = "let";   2: s = "const";  3: s = "function";
            4: s = "return"; 5: s = "if";   6: s = "else";   7: s = "for";
            8: s = "while"; 9: s = "true";  10: s = "false"; 11: s = "null";
            default: s = "undefined";
          endcase
          if ($urandom_range(0, 3) == 0) s = {s, string'(word_char(0))};
        end else begin
          n = ($urandom_range(0, 12) == 0) ? $urandom_range(62, 70) : $urandom_range(1, 10);
          s = string'(word_char(1));
          repeat (n - 1) s = {s, string'(word_char(0))};
        end
      end
      6: s = ops[$urandom_range(0, 19)];
      7: s = $urandom_range(0, 1) ? "/* x*/ **/" : "// note\n";
      8: begin
        case ($urandom_range(0, 9))
          0: c = "("; 1: c = ")"; 2: c = "{"; 3: c = "}"; 4: c = "[";
          5: c = "]"; 6: c = ";"; 7: c = ","; 8: c = "."; default: c = "%";
        endcase
        s = string'(c);
      end
      default: repeat ($urandom_range(1, 3)) s = {s, string'(8'($urandom_range(1, 255)))};
    endcase
    if ($urandom_range(0, 2) != 0) s = {s, ($urandom_range(0, 3) == 0) ? "\t" : " "};
    return s;
  endfunction

  initial begin
    int sent;
    string s;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Directed: number forms, escapes, comments, strict operators, keyword, byte extremes.
    send_text("1. .5 if a!==b/**/'\\n\\t'//x\n");
    send_byte(8'hff, 0);
    send_byte(8'h01, 0);
    send_byte(" ", 0);

    // Hold the sender until every outstanding record has drained.
    while (tracker.pending() != 0) @(negedge clk);

    sent = 0;
    while (sent < RANDOM_BYTES) begin
      s = fragment();
      send_text(s);
      sent += s.len();
    end

    // Closing phase: either drive the token count to its limit or close the
    // source with an open form still pending.
    quiet = 1;
    case ($urandom_range(0, 3))
      0, 1: while (!tracker.closed) send_byte(";", 0);
      2: begin send_text("'ab"); send_byte("\\", 1); end
      default: begin send_text("x1 +"); send_byte(8'h00, 1'($urandom_range(0, 1))); end
    endcase
    // Everything after the end token is taken and dropped.
    repeat (6) send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));

    while (tracker.pending() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (tracker.errors == 0 && tracker.pending() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
